// File: src/dmre_pkg.sv
package dmre_pkg;

  localparam int unsigned NumRegs  = 8;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 48;

  typedef enum logic [CfgIdxW-1:0] {
    RegRot0,
    RegRot1,
    RegRot2,
    RegShiftX,
    RegShiftY,
    RegShiftZ,
    RegFocal,
    RegDistK
  } reg_idx_e;

  localparam logic [47:0] RotRow0Reset = 48'h0000_0000_4000;
  localparam logic [47:0] RotRow1Reset = 48'h0000_4000_0000;
  localparam logic [47:0] RotRow2Reset = 48'h4000_0000_0000;
  localparam logic [31:0] FocalReset   = 32'h0001_0000;

  // camera point, magnitudes and projection divider
  localparam int unsigned PosW    = 50;
  localparam int unsigned MagW    = 49;
  localparam int unsigned MagLoW  = 25;
  localparam int unsigned NumW    = 81;
  localparam int unsigned ProjQW  = 31;
  // square root and scale divider
  localparam int unsigned SqrtRW  = 55;
  localparam int unsigned ScaleDW = 56;
  localparam int unsigned ScaleQW = 42;
  localparam int unsigned ScaleNW = 97;
  localparam int unsigned ScaleLoW = 21;

  localparam logic [62:0] QuarterQ46 = 63'(1) << 46;
  localparam logic [62:0] ErrMax     = '1;

  typedef struct packed {
    logic               valid;
    logic               behind;
    logic               pass;
    logic               ovf;
    logic               neg;
    logic signed [31:0] u;
    logic signed [31:0] v;
    logic signed [31:0] fx;
    logic signed [31:0] fy;
  } side_t;

endpackage

// File: src/division_model_reprojection_error.sv
// Throughput: one item per cycle; busy_o is always low.
// The pipeline is made of the bit-per-stage projection divider (31), root (55)
// and scale divider (42) pipelines plus 14 arithmetic stages.
// Reset (async, active low) empties the pipeline and loads the identity pose.
// The receiver cannot stall; each result is shown for one cycle on done_o.
module division_model_reprojection_error import dmre_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  logic signed [31:0]  world_x_i,
  input  logic signed [31:0]  world_y_i,
  input  logic signed [31:0]  world_z_i,
  input  logic signed [31:0]  feature_x_i,
  input  logic signed [31:0]  feature_y_i,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output logic                done_o,
  output logic [62:0]         sq_error_o,
  output logic                behind_camera_o,
  output logic                undistorted_passthrough_o
);

  // configuration
  logic [47:0]        rot_q   [3];
  logic signed [31:0] shift_q [3];
  logic [31:0]        focal_q;
  logic signed [31:0] dist_k_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rot_q[0]   <= RotRow0Reset;
      rot_q[1]   <= RotRow1Reset;
      rot_q[2]   <= RotRow2Reset;
      shift_q[0] <= '0;
      shift_q[1] <= '0;
      shift_q[2] <= '0;
      focal_q    <= FocalReset;
      dist_k_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        RegRot0:   rot_q[0]   <= cfg_data_i;
        RegRot1:   rot_q[1]   <= cfg_data_i;
        RegRot2:   rot_q[2]   <= cfg_data_i;
        RegShiftX: shift_q[0] <= cfg_data_i[31:0];
        RegShiftY: shift_q[1] <= cfg_data_i[31:0];
        RegShiftZ: shift_q[2] <= cfg_data_i[31:0];
        RegFocal:  focal_q    <= cfg_data_i[31:0];
        RegDistK:  dist_k_q   <= cfg_data_i[31:0];
        default: ;
      endcase
    end
  end

  assign busy_o = 1'b0;

  logic accept;
  assign accept = start_i && !busy_o;

  // S1: rotation products
  logic signed [31:0] w_in [3];
  logic signed [47:0] prod1_d [3][3];
  logic signed [47:0] prod1_q [3][3];
  side_t              sd1_d, sd1_q;

  assign w_in[0] = world_x_i;
  assign w_in[1] = world_y_i;
  assign w_in[2] = world_z_i;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        prod1_d[i][j] = 48'($signed(rot_q[i][16*j +: 16]) * w_in[j]);
      end
    end
    sd1_d       = '0;
    sd1_d.valid = accept;
    sd1_d.fx    = feature_x_i;
    sd1_d.fy    = feature_y_i;
  end

  // S2: camera point in Q.30
  logic signed [PosW-1:0] p2_d [3];
  logic signed [PosW-1:0] p2_q [3];
  side_t                  sd2_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      p2_d[i] = (PosW'(shift_q[i]) <<< 14) + PosW'(prod1_q[i][0])
              + PosW'(prod1_q[i][1]) + PosW'(prod1_q[i][2]);
    end
  end

  // S3: depth test, magnitudes, partial products with focal length
  logic [PosW-1:0]        pabs  [2];
  logic [MagW-1:0]        pmag  [2];
  logic [MagLoW+31:0]     lo3_d [2];
  logic [MagW-MagLoW+31:0] hi3_d [2];
  logic [MagLoW+31:0]     lo3_q [2];
  logic [MagW-MagLoW+31:0] hi3_q [2];
  logic [MagW-1:0]        pz3_q;
  logic                   negy3_q;
  side_t                  sd3_d, sd3_q;

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      pabs[i]  = p2_q[i][PosW-1] ? PosW'(-p2_q[i]) : PosW'(p2_q[i]);
      pmag[i]  = pabs[i][MagW-1:0];
      lo3_d[i] = pmag[i][MagLoW-1:0] * focal_q;
      hi3_d[i] = pmag[i][MagW-1:MagLoW] * focal_q;
    end
    sd3_d        = sd2_q;
    sd3_d.behind = p2_q[2][PosW-1] || (p2_q[2] == '0);
    sd3_d.neg    = p2_q[0][PosW-1];
  end

  // S4: numerators |p| * f
  logic [NumW-1:0] num4_q [2];
  logic [MagW-1:0] pz4_q;
  logic            negy4_q;
  side_t           sd4_q;
  side_t           sd4_div;
  logic [1:0]      ysd4_div;
  logic [NumW-1:0] pz_lim;

  assign pz_lim = {1'b0, pz4_q, {ProjQW{1'b0}}};

  always_comb begin
    sd4_div     = sd4_q;
    sd4_div.ovf = num4_q[0] >= pz_lim;
    ysd4_div    = {num4_q[1] >= pz_lim, negy4_q};
  end

  logic [ProjQW-1:0] quo_x, quo_y;
  side_t             sd_px;
  logic [1:0]        ysd_py;

  dmre_div #(
    .NW(NumW), .DW(MagW), .QW(ProjQW), .SW($bits(side_t))
  ) u_div_x (
    .clk_i, .rst_ni,
    .num_i(num4_q[0]), .den_i(pz4_q), .side_i(sd4_div),
    .quo_o(quo_x), .side_o(sd_px)
  );

  dmre_div #(
    .NW(NumW), .DW(MagW), .QW(ProjQW), .SW(2)
  ) u_div_y (
    .clk_i, .rst_ni,
    .num_i(num4_q[1]), .den_i(pz4_q), .side_i(ysd4_div),
    .quo_o(quo_y), .side_o(ysd_py)
  );

  // S5: saturated projection and squares
  logic [ProjQW-1:0] umag5, vmag5;
  logic [2*ProjQW-1:0] usq5_q, vsq5_q;
  side_t             sd5_d, sd5_q;

  always_comb begin
    umag5    = sd_px.ovf ? '1 : quo_x;
    vmag5    = ysd_py[1] ? '1 : quo_y;
    sd5_d    = sd_px;
    sd5_d.u  = sd_px.neg ? -$signed({1'b0, umag5}) : $signed({1'b0, umag5});
    sd5_d.v  = ysd_py[0] ? -$signed({1'b0, vmag5}) : $signed({1'b0, vmag5});
  end

  // S6: r^2 in Q.32
  logic [62:0] r2_6_q;
  side_t       sd6_q;

  // S7: |k| * r^2 partial products
  logic [31:0] kmag;
  logic [63:0] kpl7_q;
  logic [62:0] kph7_q;
  side_t       sd7_q;

  assign kmag = dist_k_q[31] ? 32'(-dist_k_q) : 32'(dist_k_q);

  // S8: T magnitude in Q.48
  logic [62:0] tmag8_q;
  side_t       sd8_q;

  // S9: case selection and root argument
  logic [62:0] inner9_q;
  side_t       sd9_d, sd9_q;

  always_comb begin
    sd9_d      = sd8_q;
    sd9_d.pass = (tmag8_q == '0) || (!dist_k_q[31] && (tmag8_q > QuarterQ46));
  end

  logic [SqrtRW-1:0] root;
  side_t             sd_rt;

  dmre_isqrt #(
    .RW(SqrtRW), .SW($bits(side_t))
  ) u_isqrt (
    .clk_i, .rst_ni,
    .num_i({1'b0, inner9_q, 46'b0}), .side_i(sd9_q),
    .root_o(root), .side_o(sd_rt)
  );

  logic [ScaleQW-1:0] scale;
  side_t              sd_sc;

  dmre_div #(
    .NW(ScaleNW), .DW(ScaleDW), .QW(ScaleQW), .SW($bits(side_t))
  ) u_div_scale (
    .clk_i, .rst_ni,
    .num_i(ScaleNW'(1) << 87),
    .den_i(ScaleDW'(QuarterQ46) + ScaleDW'(root)),
    .side_i(sd_rt),
    .quo_o(scale), .side_o(sd_sc)
  );

  // S10: |u| * scale partial products
  logic [31:0] uabs, vabs;
  logic [ProjQW+ScaleLoW-1:0] ulo10_q, uhi10_q, vlo10_q, vhi10_q;
  side_t       sd10_q;

  assign uabs = sd_sc.u[31] ? 32'(-sd_sc.u) : 32'(sd_sc.u);
  assign vabs = sd_sc.v[31] ? 32'(-sd_sc.v) : 32'(sd_sc.v);

  // S11: distorted coordinates
  logic [ProjQW+ScaleQW-1:0] ufull, vfull;
  logic [32:0]               um, vm;
  logic signed [33:0]        du11_d, dv11_d, du11_q, dv11_q;
  side_t                     sd11_q;

  always_comb begin
    ufull = {uhi10_q, {ScaleLoW{1'b0}}} + (ProjQW+ScaleQW)'(ulo10_q);
    vfull = {vhi10_q, {ScaleLoW{1'b0}}} + (ProjQW+ScaleQW)'(vlo10_q);
    um    = 33'(ufull >> 40);
    vm    = 33'(vfull >> 40);
    if (sd10_q.pass) begin
      du11_d = 34'(sd10_q.u);
      dv11_d = 34'(sd10_q.v);
    end else begin
      du11_d = sd10_q.u[31] ? -$signed({1'b0, um}) : $signed({1'b0, um});
      dv11_d = sd10_q.v[31] ? -$signed({1'b0, vm}) : $signed({1'b0, vm});
    end
  end

  // S12: differences to the feature
  logic signed [34:0] ex, ey;
  logic [33:0]        ex12_q, ey12_q;
  side_t              sd12_q;

  assign ex = 35'(du11_q) - 35'(sd11_q.fx);
  assign ey = 35'(dv11_q) - 35'(sd11_q.fy);

  // S13: squares
  logic [67:0] ex13_q, ey13_q;
  side_t       sd13_q;

  // S14: sum and saturation
  logic [68:0] esum;
  assign esum = 69'(ex13_q) + 69'(ey13_q);

  always_ff @(posedge clk_i) begin
    prod1_q <= prod1_d;
    p2_q    <= p2_d;
    lo3_q   <= lo3_d;
    hi3_q   <= hi3_d;
    pz3_q   <= p2_q[2][MagW-1:0];
    negy3_q <= p2_q[1][PosW-1];
    for (int i = 0; i < 2; i++) begin
      num4_q[i] <= {hi3_q[i], {MagLoW{1'b0}}} + NumW'(lo3_q[i]);
    end
    pz4_q    <= pz3_q;
    negy4_q  <= negy3_q;
    usq5_q   <= umag5 * umag5;
    vsq5_q   <= vmag5 * vmag5;
    r2_6_q   <= 63'(usq5_q) + 63'(vsq5_q);
    kpl7_q   <= r2_6_q[31:0] * kmag;
    kph7_q   <= r2_6_q[62:32] * kmag;
    tmag8_q  <= kph7_q + 63'(kpl7_q[63:32]);
    inner9_q <= dist_k_q[31] ? QuarterQ46 + tmag8_q : QuarterQ46 - tmag8_q;
    ulo10_q  <= uabs[30:0] * scale[ScaleLoW-1:0];
    uhi10_q  <= uabs[30:0] * scale[ScaleQW-1:ScaleLoW];
    vlo10_q  <= vabs[30:0] * scale[ScaleLoW-1:0];
    vhi10_q  <= vabs[30:0] * scale[ScaleQW-1:ScaleLoW];
    du11_q   <= du11_d;
    dv11_q   <= dv11_d;
    ex12_q   <= ex[34] ? 34'(-ex) : 34'(ex);
    ey12_q   <= ey[34] ? 34'(-ey) : 34'(ey);
    ex13_q   <= ex12_q * ex12_q;
    ey13_q   <= ey12_q * ey12_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sd1_q  <= '0;
      sd2_q  <= '0;
      sd3_q  <= '0;
      sd4_q  <= '0;
      sd5_q  <= '0;
      sd6_q  <= '0;
      sd7_q  <= '0;
      sd8_q  <= '0;
      sd9_q  <= '0;
      sd10_q <= '0;
      sd11_q <= '0;
      sd12_q <= '0;
      sd13_q <= '0;
      done_o <= 1'b0;
    end else begin
      sd1_q  <= sd1_d;
      sd2_q  <= sd1_q;
      sd3_q  <= sd3_d;
      sd4_q  <= sd3_q;
      sd5_q  <= sd5_d;
      sd6_q  <= sd5_q;
      sd7_q  <= sd6_q;
      sd8_q  <= sd7_q;
      sd9_q  <= sd9_d;
      sd10_q <= sd_sc;
      sd11_q <= sd10_q;
      sd12_q <= sd11_q;
      sd13_q <= sd12_q;
      done_o <= sd13_q.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sd13_q.behind || (esum > 69'(ErrMax))) begin
      sq_error_o <= ErrMax;
    end else begin
      sq_error_o <= esum[62:0];
    end
    behind_camera_o           <= sd13_q.behind;
    undistorted_passthrough_o <= sd13_q.pass && !sd13_q.behind;
  end

endmodule

// File: src/dmre_div.sv
module dmre_div #(
  parameter int unsigned NW = 81,
  parameter int unsigned DW = 49,
  parameter int unsigned QW = 31,
  parameter int unsigned SW = 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  input  logic [SW-1:0] side_i,
  output logic [QW-1:0] quo_o,
  output logic [SW-1:0] side_o
);

  // restoring division, one quotient bit per stage, MSB first
  logic [NW-1:0] rem_q  [QW];
  logic [DW-1:0] den_q  [QW];
  logic [QW-1:0] quo_q  [QW];
  logic [SW-1:0] side_q [QW];

  for (genvar s = 0; s < QW; s++) begin : g_stage
    localparam int unsigned B = QW - 1 - s;
    logic [NW-1:0] rem_in;
    logic [DW-1:0] den_in;
    logic [QW-1:0] quo_in;
    logic [SW-1:0] side_in;
    logic [NW-1:0] trial;
    logic          fits;
    logic [QW-1:0] quo_d;

    if (s == 0) begin : g_first
      assign rem_in  = num_i;
      assign den_in  = den_i;
      assign quo_in  = '0;
      assign side_in = side_i;
    end else begin : g_next
      assign rem_in  = rem_q[s-1];
      assign den_in  = den_q[s-1];
      assign quo_in  = quo_q[s-1];
      assign side_in = side_q[s-1];
    end

    assign trial = {{(NW-DW){1'b0}}, den_in} << B;
    assign fits  = rem_in >= trial;

    always_comb begin
      quo_d    = quo_in;
      quo_d[B] = fits;
    end

    always_ff @(posedge clk_i) begin
      rem_q[s] <= fits ? rem_in - trial : rem_in;
      den_q[s] <= den_in;
      quo_q[s] <= quo_d;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        side_q[s] <= '0;
      end else begin
        side_q[s] <= side_in;
      end
    end
  end

  assign quo_o  = quo_q[QW-1];
  assign side_o = side_q[QW-1];

endmodule

// File: src/dmre_isqrt.sv
module dmre_isqrt #(
  parameter int unsigned RW = 55,
  parameter int unsigned SW = 1
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [2*RW-1:0] num_i,
  input  logic [SW-1:0]   side_i,
  output logic [RW-1:0]   root_o,
  output logic [SW-1:0]   side_o
);

  // digit-by-digit integer root, one root bit per stage
  logic [2*RW-1:0] rem_q  [RW];
  logic [RW-1:0]   root_q [RW];
  logic [SW-1:0]   side_q [RW];

  for (genvar s = 0; s < RW; s++) begin : g_stage
    localparam int unsigned B = RW - 1 - s;
    logic [2*RW-1:0] rem_in;
    logic [RW-1:0]   root_in;
    logic [SW-1:0]   side_in;
    logic [2*RW-1:0] inc;
    logic            fits;
    logic [RW-1:0]   root_d;

    if (s == 0) begin : g_first
      assign rem_in  = num_i;
      assign root_in = '0;
      assign side_in = side_i;
    end else begin : g_next
      assign rem_in  = rem_q[s-1];
      assign root_in = root_q[s-1];
      assign side_in = side_q[s-1];
    end

    // (r + 2^B)^2 - r^2 = r * 2^(B+1) + 2^(2B)
    always_comb begin
      inc        = {{RW{1'b0}}, root_in} << (B + 1);
      inc[2*B]   = 1'b1;
      root_d     = root_in;
      root_d[B]  = fits;
    end

    assign fits = rem_in >= inc;

    always_ff @(posedge clk_i) begin
      rem_q[s]  <= fits ? rem_in - inc : rem_in;
      root_q[s] <= root_d;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        side_q[s] <= '0;
      end else begin
        side_q[s] <= side_in;
      end
    end
  end

  assign root_o = root_q[RW-1];
  assign side_o = side_q[RW-1];

endmodule
